### rtl/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

   // Fixed-point format of the plotted plane
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 26;
   localparam int INDEX_WIDTH = 12;

   // Register and field widths
   localparam int STEP_WIDTH  = COORD_WIDTH - 1;
   localparam int LIMIT_WIDTH = 10;
   localparam int SHADE_WIDTH = 4;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Mapping arithmetic
   localparam int PROD_WIDTH = INDEX_WIDTH + STEP_WIDTH;
   localparam int SUM_WIDTH  = ((PROD_WIDTH > COORD_WIDTH) ? PROD_WIDTH : COORD_WIDTH) + 2;

   // Iteration arithmetic
   localparam int SQ_WIDTH  = 2 * COORD_WIDTH;
   localparam int ACC_WIDTH = SQ_WIDTH + 1;

   // Escape thresholds: a part of magnitude 4, and |z|^2 of 16
   localparam logic [COORD_WIDTH-1:0] ESC_PART = COORD_WIDTH'(64'd4 << FRAC_BITS);
   localparam logic [ACC_WIDTH-1:0]   ESC_MAG  = ACC_WIDTH'(1) << (2 * FRAC_BITS + 4);

   // Shade scaling and its divider
   localparam int SHADE_SCALE = 9;
   localparam int REM_WIDTH   = LIMIT_WIDTH + SHADE_WIDTH;
   localparam int STEP_CNT_WIDTH = $clog2(SHADE_WIDTH);

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_MIN  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_MAX  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_STEP = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_STEP = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LIMIT  = 3'd4;

   // Register reset values
   localparam logic [COORD_WIDTH-1:0] X_MIN_RESET  = 32'hE000_0000;
   localparam logic [COORD_WIDTH-1:0] Y_MAX_RESET  = 32'h0400_0000;
   localparam logic [STEP_WIDTH-1:0]  X_STEP_RESET = 31'h0010_0000;
   localparam logic [STEP_WIDTH-1:0]  Y_STEP_RESET = 31'h0010_0000;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET  = 10'd100;

   // Mapped point handed from front to back
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] cr;
      logic signed [COORD_WIDTH-1:0] ci;
   } coord_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ITER,
      ST_DIV,
      ST_HOLD
   } iter_state_type;

endpackage

`default_nettype wire

### rtl/mbe_front.sv
`default_nettype none

module mbe_front
   import mbe_pkg::*;
(
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire        [INDEX_WIDTH-1:0]  req_column,
   input  wire        [INDEX_WIDTH-1:0]  req_row,
   input  wire signed [COORD_WIDTH-1:0]  x_min,
   input  wire signed [COORD_WIDTH-1:0]  y_max,
   input  wire        [STEP_WIDTH-1:0]   x_step,
   input  wire        [STEP_WIDTH-1:0]   y_step,
   output logic                          push,
   output coord_type                     push_data,
   input  wire                           queue_full
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [PROD_WIDTH-1:0] prod_x_ff, prod_y_ff;
   logic                  accept;
   logic signed [SUM_WIDTH-1:0] sum_x, sum_y;

   function automatic logic signed [COORD_WIDTH-1:0] saturate(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic [SUM_WIDTH-COORD_WIDTH:0] top;
      top = v[SUM_WIDTH-1:COORD_WIDTH-1];
      if ((top == '0) || (top == '1)) begin
         return v[COORD_WIDTH-1:0];
      end else if (v[SUM_WIDTH-1]) begin
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   endfunction

   // Hold a request while its mapped point cannot enter the queue
   assign req_stall = s1_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = s1_valid_ff && !queue_full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Scale pixel indexes by the step sizes
   always_ff @(posedge clock) begin
      if (accept) begin
         prod_x_ff <= PROD_WIDTH'(req_column) * PROD_WIDTH'(x_step);
         prod_y_ff <= PROD_WIDTH'(req_row) * PROD_WIDTH'(y_step);
      end
   end

   // Offset from the plot edges and clamp to the coordinate range
   always_comb begin
      sum_x = $signed({{(SUM_WIDTH-COORD_WIDTH){x_min[COORD_WIDTH-1]}}, x_min})
            + $signed({{(SUM_WIDTH-PROD_WIDTH){1'b0}}, prod_x_ff});
      sum_y = $signed({{(SUM_WIDTH-COORD_WIDTH){y_max[COORD_WIDTH-1]}}, y_max})
            - $signed({{(SUM_WIDTH-PROD_WIDTH){1'b0}}, prod_y_ff});
      push_data.cr = saturate(sum_x);
      push_data.ci = saturate(sum_y);
   end

endmodule

`default_nettype wire

### rtl/mbe_queue.sv
`default_nettype none

module mbe_queue
   import mbe_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        push,
   input  coord_type  push_data,
   output logic       full,
   output logic       not_empty,
   input  wire        pop,
   output coord_type  pop_data
);

   coord_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/mbe_iter.sv
`default_nettype none

module mbe_iter
   import mbe_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      queue_not_empty,
   input  coord_type                queue_data,
   output logic                     pop,
   input  wire  [LIMIT_WIDTH-1:0]   limit,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [LIMIT_WIDTH-1:0]   rsp_iterations,
   output logic                     rsp_in_set,
   output logic [SHADE_WIDTH-1:0]   rsp_shade
);

   iter_state_type state_ff, state_in;

   logic signed [COORD_WIDTH-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic signed [COORD_WIDTH-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic [LIMIT_WIDTH-1:0]        n_ff, n_in;
   logic                          in_set_ff, in_set_in;
   logic [REM_WIDTH-1:0]          rem_ff, rem_in;
   logic [SHADE_WIDTH-1:0]        quo_ff, quo_in;
   logic [STEP_CNT_WIDTH-1:0]     step_ff, step_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_WIDTH-1:0]        rsp_iterations_ff;
   logic                          rsp_in_set_ff;
   logic [SHADE_WIDTH-1:0]        rsp_shade_ff;
   logic                          out_free, load_out;

   logic signed [SQ_WIDTH-1:0]    zr_sq, zi_sq, zri;
   logic [COORD_WIDTH-1:0]        zr_mag, zi_mag;
   logic [ACC_WIDTH-1:0]          mag_sum;
   logic signed [ACC_WIDTH-1:0]   re_full, im_full, re_sh, im_sh;
   logic                          escape;
   logic [REM_WIDTH-1:0]          divisor;

   // Complex square and escape test on the current z
   always_comb begin
      zr_sq   = zr_ff * zr_ff;
      zi_sq   = zi_ff * zi_ff;
      zri     = zr_ff * zi_ff;
      zr_mag  = zr_ff[COORD_WIDTH-1] ? COORD_WIDTH'(-zr_ff) : zr_ff;
      zi_mag  = zi_ff[COORD_WIDTH-1] ? COORD_WIDTH'(-zi_ff) : zi_ff;
      mag_sum = {1'b0, zr_sq} + {1'b0, zi_sq};
      escape  = (zr_mag >= ESC_PART) || (zi_mag >= ESC_PART) || (mag_sum >= ESC_MAG);
      re_full = {zr_sq[SQ_WIDTH-1], zr_sq} - {zi_sq[SQ_WIDTH-1], zi_sq};
      im_full = {zri, 1'b0};
      re_sh   = re_full >>> FRAC_BITS;
      im_sh   = im_full >>> FRAC_BITS;
   end

   assign divisor  = REM_WIDTH'(limit) << step_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = (state_ff == ST_HOLD) && out_free;

   // Sequence: take a point, iterate, scale the shade of an escaped point, hand off the result
   always_comb begin
      state_in  = state_ff;
      cr_in     = cr_ff;
      ci_in     = ci_ff;
      zr_in     = zr_ff;
      zi_in     = zi_ff;
      n_in      = n_ff;
      in_set_in = in_set_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      pop       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (queue_not_empty) begin
               pop      = 1'b1;
               cr_in    = queue_data.cr;
               ci_in    = queue_data.ci;
               zr_in    = queue_data.cr;
               zi_in    = queue_data.ci;
               n_in     = '0;
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            if (n_ff == limit) begin
               in_set_in = 1'b1;
               quo_in    = '0;
               state_in  = ST_HOLD;
            end else if (escape) begin
               in_set_in = 1'b0;
               rem_in    = REM_WIDTH'(n_ff) * REM_WIDTH'(SHADE_SCALE);
               quo_in    = '0;
               step_in   = STEP_CNT_WIDTH'(SHADE_WIDTH - 1);
               state_in  = ST_DIV;
            end else begin
               zr_in = re_sh[COORD_WIDTH-1:0] + cr_ff;
               zi_in = im_sh[COORD_WIDTH-1:0] + ci_ff;
               n_in  = n_ff + 1'b1;
            end
         end
         ST_DIV: begin
            // One restoring quotient bit per cycle, most significant first
            if (rem_ff >= divisor) begin
               rem_in          = rem_ff - divisor;
               quo_in[step_ff] = 1'b1;
            end
            if (step_ff == '0) begin
               state_in = ST_HOLD;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      zr_ff     <= zr_in;
      zi_ff     <= zi_in;
      n_ff      <= n_in;
      in_set_ff <= in_set_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_iterations_ff <= n_ff;
         rsp_in_set_ff     <= in_set_ff;
         rsp_shade_ff      <= quo_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iterations = rsp_iterations_ff;
   assign rsp_in_set     = rsp_in_set_ff;
   assign rsp_shade      = rsp_shade_ff;

`ifndef SYNTH
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER) |-> (n_ff <= limit))
      else $error("iteration count passed the limit");

   a_in_set_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_in_set_ff) |-> (rsp_shade_ff == '0))
      else $error("in-set result carries a nonzero shade");

   a_shade_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_shade_ff <= SHADE_WIDTH'(SHADE_SCALE)))
      else $error("shade out of range");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      pop |=> ((state_ff == ST_ITER) && (n_ff == '0)))
      else $error("popped point did not start iterating");
`endif

endmodule

`default_nettype wire

### rtl/mandelbrot_escape_time.sv
// Escape-time pixel unit.
// Request channel (req_valid/req_stall, req_column, req_row): one pixel per
// request; taken at a clock edge with req_valid high and req_stall low.
// Response channel (rsp_valid/rsp_stall): one result per request, in order,
// with the iteration count, the in-set flag and a shade digit 0..8.
// Register port (csr_valid/csr_ready, csr_index, csr_wdata): plot edges,
// step sizes and iteration limit; csr_ready is always high.
// The complex step unit does one iteration per cycle, and an escaped point
// then passes through the shade divider before its result is registered.
// Points are iterated one at a time by the single iteration unit; the front
// end maps the next pixel and a two-entry queue holds mapped points while
// the unit is busy.
// A stalled response is held in the output register; the unit then waits,
// the queue fills and req_stall rises.
// Reset (synchronous) empties the pipeline and loads the default view:
// x_min -8.0, y_max 1.0, steps 1/64, limit 100.
`default_nettype none

module mandelbrot_escape_time
   import mbe_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  [INDEX_WIDTH-1:0]      req_column,
   input  wire  [INDEX_WIDTH-1:0]      req_row,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [LIMIT_WIDTH-1:0]      rsp_iterations,
   output logic                        rsp_in_set,
   output logic [SHADE_WIDTH-1:0]      rsp_shade,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire  [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire  [CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic signed [COORD_WIDTH-1:0] x_min_ff, y_max_ff;
   logic [STEP_WIDTH-1:0]         x_step_ff, y_step_ff;
   logic [LIMIT_WIDTH-1:0]        limit_ff;

   logic      push, queue_full, queue_not_empty, pop;
   coord_type push_data, pop_data;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff  <= X_MIN_RESET;
         y_max_ff  <= Y_MAX_RESET;
         x_step_ff <= X_STEP_RESET;
         y_step_ff <= Y_STEP_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_X_MIN:  x_min_ff  <= csr_wdata[COORD_WIDTH-1:0];
            CSR_Y_MAX:  y_max_ff  <= csr_wdata[COORD_WIDTH-1:0];
            CSR_X_STEP: x_step_ff <= csr_wdata[STEP_WIDTH-1:0];
            CSR_Y_STEP: y_step_ff <= csr_wdata[STEP_WIDTH-1:0];
            CSR_LIMIT:  limit_ff  <= csr_wdata[LIMIT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   mbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_column (req_column),
      .req_row    (req_row),
      .x_min      (x_min_ff),
      .y_max      (y_max_ff),
      .x_step     (x_step_ff),
      .y_step     (y_step_ff),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   mbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (pop),
      .pop_data  (pop_data)
   );

   mbe_iter u_iter (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_data      (pop_data),
      .pop             (pop),
      .limit           (limit_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_iterations  (rsp_iterations),
      .rsp_in_set      (rsp_in_set),
      .rsp_shade       (rsp_shade)
   );

endmodule

`default_nettype wire
